// ===== rtl/hbs_pkg.sv =====
package hbs_pkg;

   localparam int COORD_W   = 24;
   localparam int DIM_W     = 9;
   localparam int ADDR_W    = 16;
   localparam int SAMPLE_W  = 8;
   localparam int HEIGHT_W  = 16;
   localparam int CSR_W     = 24;
   localparam int CSR_IDX_W = 2;

   localparam int MAX_DIM     = 256;
   localparam int FRAC_BITS   = 8;
   localparam int STORE_DEPTH = 1 << ADDR_W;
   localparam int READ_PORTS  = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_GRID_ROWS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_COLS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Z  = 2'd3;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam logic [DIM_W-1:0]   GRID_DIM_RESET = 9'd256;
   localparam logic [COORD_W-1:0] ORIGIN_RESET   = 24'd0;

   typedef struct packed {
      logic                        command;
      logic [ADDR_W-1:0]           write_index;
      logic [SAMPLE_W-1:0]         sample_value;
      logic signed [COORD_W-1:0]   query_x;
      logic signed [COORD_W-1:0]   query_z;
   } req_payload_type;

   typedef struct packed {
      logic [HEIGHT_W-1:0] height_value;
      logic                on_terrain;
   } rsp_payload_type;

endpackage

// ===== rtl/heightmap_bilinear_sampler.sv =====
// A query passes stage registers 1 to 6 in order; a write gives no result.
// One beat per cycle, writes and queries alike, while no result is stalled.
// All six stages advance together and hold while a finished result is stalled.
// Four copies of the sample store, each with one read port, serve the four corner reads.
// Synchronous reset clears the valid bits and sets 256 x 256 cells at origin (0,0);
// the sample store is not cleared and holds garbage until written.
module heightmap_bilinear_sampler #(
   parameter int FRAC_BITS = hbs_pkg::FRAC_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  hbs_pkg::req_payload_type        req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output hbs_pkg::rsp_payload_type        rsp_data,
   input  logic                            csr_write_enable,
   input  logic [hbs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [hbs_pkg::CSR_W-1:0]       csr_write_data
);

   localparam int COORD_W  = hbs_pkg::COORD_W;
   localparam int DIM_W    = hbs_pkg::DIM_W;
   localparam int ADDR_W   = hbs_pkg::ADDR_W;
   localparam int SAMPLE_W = hbs_pkg::SAMPLE_W;
   localparam int HEIGHT_W = hbs_pkg::HEIGHT_W;
   localparam int PORTS    = hbs_pkg::READ_PORTS;
   localparam int DIFF_W   = COORD_W + 1;
   localparam int IH_W     = DIFF_W - 1 - FRAC_BITS;
   localparam int CMP_W    = ((IH_W > DIM_W) ? IH_W : DIM_W) + 1;
   localparam int WT_W     = FRAC_BITS + 1;
   localparam int A_W      = SAMPLE_W + FRAC_BITS;
   localparam int FULL_W   = SAMPLE_W + 2 * FRAC_BITS;
   localparam int SHIFT    = 2 * FRAC_BITS - SAMPLE_W;
   localparam int PROD_W   = 2 * DIM_W;
   localparam logic [WT_W-1:0]  ONE = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [DIM_W-1:0] DIM_LIMIT = DIM_W'(hbs_pkg::MAX_DIM);

   logic [DIM_W-1:0]   rows_ff, rows_in, cols_ff, cols_in;
   logic [COORD_W-1:0] ox_ff, ox_in, oz_ff, oz_in;
   logic [DIM_W-1:0]   rows_c, cols_c;

   logic advance;

   // Stage 1: origin subtracted.
   logic               v1_ff, v1_in, q1_ff, q1_in;
   logic [ADDR_W-1:0]  wi1_ff, wi1_in;
   logic [SAMPLE_W-1:0] sv1_ff, sv1_in;
   logic [DIFF_W-1:0]  dx1_ff, dx1_in, dz1_ff, dz1_in;

   // Stage 2: range checks and row times stride.
   logic               v2_ff, v2_in, q2_ff, q2_in, off2_ff, off2_in, last2_ff, last2_in;
   logic [ADDR_W-1:0]  wi2_ff, wi2_in;
   logic [SAMPLE_W-1:0] sv2_ff, sv2_in;
   logic [DIM_W-1:0]   col2_ff, col2_in;
   logic [PROD_W-1:0]  prod2_ff, prod2_in;
   logic [FRAC_BITS-1:0] fh2_ff, fh2_in, fw2_ff, fw2_in;

   // Stage 3: corner addresses.
   logic               v3_ff, v3_in, q3_ff, q3_in, off3_ff, off3_in, last3_ff, last3_in;
   logic [ADDR_W-1:0]  wi3_ff, wi3_in;
   logic [SAMPLE_W-1:0] sv3_ff, sv3_in;
   logic [ADDR_W-1:0]  addr3_ff [PORTS];
   logic [ADDR_W-1:0]  addr3_in [PORTS];
   logic [FRAC_BITS-1:0] fh3_ff, fh3_in, fw3_ff, fw3_in;

   // Stage 4: corner samples read.
   logic               v4_ff, v4_in, q4_ff, q4_in, off4_ff, off4_in, last4_ff, last4_in;
   logic [SAMPLE_W-1:0] smp4_ff [PORTS];
   logic [FRAC_BITS-1:0] fh4_ff, fh4_in, fw4_ff, fw4_in;

   // Stage 5: blend along z.
   logic               v5_ff, v5_in, q5_ff, q5_in, off5_ff, off5_in, last5_ff, last5_in;
   logic [SAMPLE_W-1:0] s005_ff, s005_in;
   logic [A_W-1:0]     a5_ff, a5_in, b5_ff, b5_in;
   logic [FRAC_BITS-1:0] fh5_ff, fh5_in;

   // Stage 6: blend along x, result register.
   logic               rsp_valid_ff, rsp_valid_in;
   hbs_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;

   logic [SAMPLE_W-1:0] store_mem [PORTS][hbs_pkg::STORE_DEPTH];

   logic [IH_W-1:0]    ih, iw;
   logic [CMP_W-1:0]   ih_ext, iw_ext, rows_ext, cols_ext;
   logic [DIM_W-1:0]   row2;
   logic [ADDR_W-1:0]  base3;
   logic [FULL_W-1:0]  full6;
   logic               store_write;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign rows_c = (rows_ff > DIM_LIMIT) ? DIM_LIMIT : rows_ff;
   assign cols_c = (cols_ff > DIM_LIMIT) ? DIM_LIMIT : cols_ff;

   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      ox_in   = ox_ff;
      oz_in   = oz_ff;
      if (csr_write_enable) begin
         case (csr_index)
            hbs_pkg::CSR_GRID_ROWS: rows_in = csr_write_data[DIM_W-1:0];
            hbs_pkg::CSR_GRID_COLS: cols_in = csr_write_data[DIM_W-1:0];
            hbs_pkg::CSR_ORIGIN_X:  ox_in   = csr_write_data[COORD_W-1:0];
            hbs_pkg::CSR_ORIGIN_Z:  oz_in   = csr_write_data[COORD_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      v1_in  = req_valid;
      q1_in  = req_data.command == hbs_pkg::CMD_QUERY;
      wi1_in = req_data.write_index;
      sv1_in = req_data.sample_value;
      dx1_in = {req_data.query_x[COORD_W-1], req_data.query_x} - {ox_ff[COORD_W-1], ox_ff};
      dz1_in = {req_data.query_z[COORD_W-1], req_data.query_z} - {oz_ff[COORD_W-1], oz_ff};

      ih       = dx1_ff[DIFF_W-2:FRAC_BITS];
      iw       = dz1_ff[DIFF_W-2:FRAC_BITS];
      ih_ext   = CMP_W'(ih);
      iw_ext   = CMP_W'(iw);
      rows_ext = CMP_W'(rows_c);
      cols_ext = CMP_W'(cols_c);
      row2     = DIM_W'(ih);
      v2_in    = v1_ff;
      q2_in    = q1_ff;
      wi2_in   = wi1_ff;
      sv2_in   = sv1_ff;
      off2_in  = dx1_ff[DIFF_W-1] || dz1_ff[DIFF_W-1] ||
                 (ih_ext >= rows_ext) || (iw_ext >= cols_ext);
      last2_in = (ih_ext + CMP_W'(1) >= rows_ext) || (iw_ext + CMP_W'(1) >= cols_ext);
      col2_in  = DIM_W'(iw);
      prod2_in = PROD_W'(row2) * PROD_W'(cols_c);
      fh2_in   = dx1_ff[FRAC_BITS-1:0];
      fw2_in   = dz1_ff[FRAC_BITS-1:0];

      base3       = ADDR_W'(prod2_ff + PROD_W'(col2_ff));
      v3_in       = v2_ff;
      q3_in       = q2_ff;
      off3_in     = off2_ff;
      last3_in    = last2_ff;
      wi3_in      = wi2_ff;
      sv3_in      = sv2_ff;
      fh3_in      = fh2_ff;
      fw3_in      = fw2_ff;
      addr3_in[0] = base3;
      addr3_in[1] = base3 + ADDR_W'(1);
      addr3_in[2] = base3 + ADDR_W'(cols_c);
      addr3_in[3] = base3 + ADDR_W'(cols_c) + ADDR_W'(1);

      v4_in    = v3_ff;
      q4_in    = q3_ff;
      off4_in  = off3_ff;
      last4_in = last3_ff;
      fh4_in   = fh3_ff;
      fw4_in   = fw3_ff;

      v5_in    = v4_ff;
      q5_in    = q4_ff;
      off5_in  = off4_ff;
      last5_in = last4_ff;
      fh5_in   = fh4_ff;
      s005_in  = smp4_ff[0];
      a5_in    = A_W'(smp4_ff[0]) * A_W'(ONE - WT_W'(fw4_ff)) +
                 A_W'(smp4_ff[1]) * A_W'(fw4_ff);
      b5_in    = A_W'(smp4_ff[2]) * A_W'(ONE - WT_W'(fw4_ff)) +
                 A_W'(smp4_ff[3]) * A_W'(fw4_ff);

      full6        = FULL_W'(a5_ff) * FULL_W'(ONE - WT_W'(fh5_ff)) +
                     FULL_W'(b5_ff) * FULL_W'(fh5_ff);
      rsp_valid_in = v5_ff && q5_ff;
      rsp_data_in.on_terrain = !off5_ff;
      if (off5_ff) begin
         rsp_data_in.height_value = '0;
      end else if (last5_ff) begin
         rsp_data_in.height_value = {s005_ff, {(HEIGHT_W - SAMPLE_W){1'b0}}};
      end else begin
         rsp_data_in.height_value = HEIGHT_W'(full6 >> SHIFT);
      end
   end

   assign store_write = advance && v3_ff && !q3_ff;

   for (genvar p = 0; p < PORTS; p++) begin : g_store
      always_ff @(posedge clock) begin
         if (store_write) begin
            store_mem[p][wi3_ff] <= sv3_ff;
         end
         if (advance) begin
            smp4_ff[p] <= store_mem[p][addr3_ff[p]];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff      <= hbs_pkg::GRID_DIM_RESET;
         cols_ff      <= hbs_pkg::GRID_DIM_RESET;
         ox_ff        <= hbs_pkg::ORIGIN_RESET;
         oz_ff        <= hbs_pkg::ORIGIN_RESET;
      end else begin
         rows_ff      <= rows_in;
         cols_ff      <= cols_in;
         ox_ff        <= ox_in;
         oz_ff        <= oz_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         v3_ff        <= v3_in;
         v4_ff        <= v4_in;
         v5_ff        <= v5_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         q1_ff       <= q1_in;
         wi1_ff      <= wi1_in;
         sv1_ff      <= sv1_in;
         dx1_ff      <= dx1_in;
         dz1_ff      <= dz1_in;
         q2_ff       <= q2_in;
         off2_ff     <= off2_in;
         last2_ff    <= last2_in;
         wi2_ff      <= wi2_in;
         sv2_ff      <= sv2_in;
         col2_ff     <= col2_in;
         prod2_ff    <= prod2_in;
         fh2_ff      <= fh2_in;
         fw2_ff      <= fw2_in;
         q3_ff       <= q3_in;
         off3_ff     <= off3_in;
         last3_ff    <= last3_in;
         wi3_ff      <= wi3_in;
         sv3_ff      <= sv3_in;
         addr3_ff    <= addr3_in;
         fh3_ff      <= fh3_in;
         fw3_ff      <= fw3_in;
         q4_ff       <= q4_in;
         off4_ff     <= off4_in;
         last4_ff    <= last4_in;
         fh4_ff      <= fh4_in;
         fw4_ff      <= fw4_in;
         q5_ff       <= q5_in;
         off5_ff     <= off5_in;
         last5_ff    <= last5_in;
         s005_ff     <= s005_in;
         a5_ff       <= a5_in;
         b5_ff       <= b5_in;
         fh5_ff      <= fh5_in;
         rsp_data_ff <= rsp_data_in;
      end
   end

   a_off_terrain_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.on_terrain |-> rsp_data_ff.height_value == '0)
      else $error("off-terrain result carries a nonzero height");

   a_pipe_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable({v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, rsp_valid_ff}))
      else $error("pipeline moved while the result beat was stalled");

   a_query_emerges: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff == $past(v5_ff && q5_ff))
      else $error("result valid does not follow the last stage");

   a_no_write_when_stalled: assert property (@(posedge clock) disable iff (reset)
      store_write |-> advance && !q3_ff)
      else $error("sample store written outside a moving write beat");

endmodule

// ===== verif/height_checker.sv =====
module height_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  hbs_pkg::req_payload_type      req_data,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  hbs_pkg::rsp_payload_type      rsp_data,
   input  logic                          csr_write_enable,
   input  logic [hbs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [hbs_pkg::CSR_W-1:0]     csr_write_data,
   output int                            mismatches,
   output int                            pending
);
   import hbs_pkg::*;

   localparam int ONE = 1 << FRAC_BITS;

   logic [SAMPLE_W-1:0] samples [0:STORE_DEPTH-1];
   logic [DIM_W-1:0]    grid_rows_cfg;
   logic [DIM_W-1:0]    grid_cols_cfg;
   int                  origin_x_cfg;
   int                  origin_z_cfg;
   rsp_payload_type     expected_heights [$];

   function automatic int clamp_dim(input logic [DIM_W-1:0] d);
      return (d > MAX_DIM) ? MAX_DIM : int'(d);
   endfunction

   function automatic int sample_at(input int row, input int col, input int cols);
      return int'(samples[(row * cols + col) & (STORE_DEPTH - 1)]);
   endfunction

   function automatic rsp_payload_type predict_height(input req_payload_type beat);
      rsp_payload_type r;
      int qx, qz, hs, ws, nr, nc, ih, iw, fh, fw;
      int s00, s01, s10, s11, upper, lower, blend;
      r = '0;
      qx = int'(beat.query_x);
      qz = int'(beat.query_z);
      nr = clamp_dim(grid_rows_cfg);
      nc = clamp_dim(grid_cols_cfg);
      hs = qx - origin_x_cfg;
      ws = qz - origin_z_cfg;
      if (hs < 0 || ws < 0) begin
         return r;
      end
      ih = hs >> FRAC_BITS;
      iw = ws >> FRAC_BITS;
      if (ih >= nr || iw >= nc) begin
         return r;
      end
      r.on_terrain = 1'b1;
      if (ih + 1 >= nr || iw + 1 >= nc) begin
         r.height_value = HEIGHT_W'((sample_at(ih, iw, nc) << 8) & 16'hFFFF);
         return r;
      end
      fh = hs & (ONE - 1);
      fw = ws & (ONE - 1);
      s00 = sample_at(ih, iw, nc);
      s01 = sample_at(ih, iw + 1, nc);
      s10 = sample_at(ih + 1, iw, nc);
      s11 = sample_at(ih + 1, iw + 1, nc);
      upper = s00 * (ONE - fw) + s01 * fw;
      lower = s10 * (ONE - fw) + s11 * fw;
      blend = upper * (ONE - fh) + lower * fh;
      r.height_value = HEIGHT_W'((blend >> (2 * FRAC_BITS - 8)) & 16'hFFFF);
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         expected_heights.delete();
         mismatches = 0;
         grid_rows_cfg = GRID_DIM_RESET;
         grid_cols_cfg = GRID_DIM_RESET;
         origin_x_cfg = 0;
         origin_z_cfg = 0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_GRID_ROWS: grid_rows_cfg = csr_write_data[DIM_W-1:0];
               CSR_GRID_COLS: grid_cols_cfg = csr_write_data[DIM_W-1:0];
               CSR_ORIGIN_X:  origin_x_cfg = int'($signed(csr_write_data));
               CSR_ORIGIN_Z:  origin_z_cfg = int'($signed(csr_write_data));
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            if (req_data.command == CMD_WRITE) begin
               samples[req_data.write_index] = req_data.sample_value;
            end else begin
               expected_heights.insert(expected_heights.size(), predict_height(req_data));
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_heights.size() == 0) begin
               $display("%0t: unexpected result beat: expected none, actual height %0d on %0b",
                        $time, rsp_data.height_value, rsp_data.on_terrain);
               mismatches++;
            end else begin
               want = expected_heights.pop_front();
               if (rsp_data.height_value !== want.height_value) begin
                  $display("%0t: height_value expected %0d, actual %0d",
                           $time, want.height_value, rsp_data.height_value);
                  mismatches++;
               end
               if (rsp_data.on_terrain !== want.on_terrain) begin
                  $display("%0t: on_terrain expected %0b, actual %0b",
                           $time, want.on_terrain, rsp_data.on_terrain);
                  mismatches++;
               end
            end
         end
      end
      pending = expected_heights.size();
   end

endmodule

// ===== verif/tb_heightmap_bilinear_sampler.sv =====
module tb_heightmap_bilinear_sampler;
   import hbs_pkg::*;

   localparam int QUIET_LIMIT     = 2000;
   localparam int SETTLE_CYCLES   = 12;
   localparam int PHASES          = 12;
   localparam int BEATS_PER_PHASE = 135;
   localparam int COORD_MAX       = (1 << (COORD_W - 1)) - 1;
   localparam int COORD_MIN       = -(1 << (COORD_W - 1));

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   req_payload_type      req_data;
   logic                 rsp_valid;
   logic                 rsp_stall;
   rsp_payload_type      rsp_data;
   logic                 csr_write_enable;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_write_data;

   int               mismatches;
   int               pending;
   int               quiet_cycles = 0;
   int               beats_sent = 0;
   bit               req_idle_on = 1'b0;
   bit               rsp_idle_on = 1'b0;
   bit               written [0:STORE_DEPTH-1];
   logic [DIM_W-1:0] rows_set;
   logic [DIM_W-1:0] cols_set;
   int               origin_x_set;
   int               origin_z_set;

   heightmap_bilinear_sampler uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   height_checker height_check (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .mismatches(mismatches),
      .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_idle_on && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 16)) @(negedge clock);
         end
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("heightmap_bilinear_sampler test failed");
         $finish;
      end
   end

   function automatic int eff_dim(input logic [DIM_W-1:0] d);
      return (d > MAX_DIM) ? MAX_DIM : int'(d);
   endfunction

   function automatic int clamp_coord(input int v);
      if (v > COORD_MAX) begin
         return COORD_MAX;
      end
      if (v < COORD_MIN) begin
         return COORD_MIN;
      end
      return v;
   endfunction

   function automatic req_payload_type random_payload();
      req_payload_type p;
      p.command = 1'($urandom_range(0, 1));
      p.write_index = ADDR_W'($urandom);
      p.sample_value = SAMPLE_W'($urandom);
      p.query_x = COORD_W'($urandom);
      p.query_z = COORD_W'($urandom);
      return p;
   endfunction

   // Called at a falling edge; returns at the falling edge after the beat is taken,
   // with valid still high so that a following beat can go out back to back.
   task automatic push_beat(input req_payload_type beat);
      if (req_idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= beat;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      beats_sent++;
   endtask

   task automatic write_sample(input int addr, input int value);
      req_payload_type beat;
      beat = random_payload();
      beat.command = CMD_WRITE;
      beat.write_index = ADDR_W'(addr);
      beat.sample_value = SAMPLE_W'(value);
      written[addr & (STORE_DEPTH - 1)] = 1'b1;
      push_beat(beat);
   endtask

   task automatic cover_cell(input int addr);
      if (!written[addr]) begin
         write_sample(addr, $urandom_range(0, 255));
      end
   endtask

   // Every cell that the query will read is loaded first.
   task automatic query_at(input int qx, input int qz);
      int nr, nc, hs, ws, ih, iw;
      req_payload_type beat;
      qx = clamp_coord(qx);
      qz = clamp_coord(qz);
      nr = eff_dim(rows_set);
      nc = eff_dim(cols_set);
      hs = qx - origin_x_set;
      ws = qz - origin_z_set;
      if (hs >= 0 && ws >= 0 && (hs >> FRAC_BITS) < nr && (ws >> FRAC_BITS) < nc) begin
         ih = hs >> FRAC_BITS;
         iw = ws >> FRAC_BITS;
         cover_cell(ih * nc + iw);
         if (ih + 1 < nr && iw + 1 < nc) begin
            cover_cell(ih * nc + iw + 1);
            cover_cell((ih + 1) * nc + iw);
            cover_cell((ih + 1) * nc + iw + 1);
         end
      end
      beat = random_payload();
      beat.command = CMD_QUERY;
      beat.query_x = COORD_W'(qx);
      beat.query_z = COORD_W'(qz);
      push_beat(beat);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(negedge clock);
   endtask

   task automatic set_grid(input int rows, input int cols, input int ox, input int oz);
      logic [CSR_W-1:0] data;
      drain();
      data = CSR_W'($urandom);
      data[DIM_W-1:0] = DIM_W'(rows);
      write_csr(CSR_GRID_ROWS, data);
      data = CSR_W'($urandom);
      data[DIM_W-1:0] = DIM_W'(cols);
      write_csr(CSR_GRID_COLS, data);
      write_csr(CSR_ORIGIN_X, CSR_W'(ox));
      write_csr(CSR_ORIGIN_Z, CSR_W'(oz));
      csr_write_enable <= 1'b0;
      rows_set = DIM_W'(rows);
      cols_set = DIM_W'(cols);
      origin_x_set = clamp_coord(ox);
      origin_z_set = clamp_coord(oz);
   endtask

   task automatic random_item();
      int pick, nr, nc, gr, gc, lx, lz;
      logic [COORD_W-1:0] raw_x, raw_z;
      nr = eff_dim(rows_set);
      nc = eff_dim(cols_set);
      gr = (nr == 0) ? 1 : nr;
      gc = (nc == 0) ? 1 : nc;
      lx = ($urandom_range(0, gr - 1) << FRAC_BITS) + $urandom_range(0, 255);
      lz = ($urandom_range(0, gc - 1) << FRAC_BITS) + $urandom_range(0, 255);
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
         write_sample($urandom_range(0, STORE_DEPTH - 1), $urandom_range(0, 255));
      end else if (pick < 16) begin
         raw_x = COORD_W'($urandom);
         raw_z = COORD_W'($urandom);
         query_at(int'($signed(raw_x)), int'($signed(raw_z)));
      end else begin
         if (pick < 21) begin
            if ($urandom_range(0, 1)) begin
               lx = 0 - int'($urandom_range(1, 600));
            end else begin
               lz = 0 - int'($urandom_range(1, 600));
            end
         end else if (pick < 26) begin
            if ($urandom_range(0, 1)) begin
               lx = (nr << FRAC_BITS) + $urandom_range(0, 600);
            end else begin
               lz = (nc << FRAC_BITS) + $urandom_range(0, 600);
            end
         end else if (pick < 34) begin
            if ($urandom_range(0, 1)) begin
               lx = ((gr - 1) << FRAC_BITS) + $urandom_range(0, 255);
            end else begin
               lz = ((gc - 1) << FRAC_BITS) + $urandom_range(0, 255);
            end
         end else if (pick < 42) begin
            lx = lx & ~255;
            lz = lz & ~255;
         end
         query_at(origin_x_set + lx, origin_z_set + lz);
      end
   endtask

   initial begin
      int phase, rows, cols, ox, oz, target;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      rows_set = GRID_DIM_RESET;
      cols_set = GRID_DIM_RESET;
      origin_x_set = 0;
      origin_z_set = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed beats on the reset grid of 256 x 256 cells at the origin.
      write_sample(0, 255);
      write_sample(1, 0);
      write_sample(256, 0);
      write_sample(257, 255);
      write_sample(STORE_DEPTH - 1, 8'hA5);
      query_at(0, 0);
      query_at(128, 128);
      query_at(255, 255);
      query_at(-1, 0);
      query_at(0, -1);
      query_at(255 * 256 + 128, 255 * 256 + 200);
      query_at(255 * 256, 10);
      query_at(10, 255 * 256 + 7);
      query_at(256 * 256, 0);
      query_at(0, 256 * 256);
      query_at(COORD_MAX, COORD_MIN);
      query_at(COORD_MIN, COORD_MAX);

      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin rows = 256; cols = 256; ox = 0;         oz = 0;         end
            1: begin rows = 4;   cols = 5;   ox = 256;       oz = -640;      end
            2: begin rows = 1;   cols = 1;   ox = -77;       oz = 300;       end
            3: begin rows = 2;   cols = 2;   ox = COORD_MIN; oz = COORD_MAX; end
            4: begin rows = 256; cols = 256; ox = COORD_MIN; oz = COORD_MIN; end
            5: begin rows = 0;   cols = 7;   ox = 0;         oz = 0;         end
            6: begin rows = 511; cols = 300; ox = 0;         oz = 1000;      end
            7: begin rows = 257; cols = 1;   ox = -5000;     oz = 3;         end
            8: begin rows = 9;   cols = 0;   ox = 12;        oz = -12;       end
            default: begin
               rows = $urandom_range(1, 12);
               cols = $urandom_range(1, 12);
               ox = $urandom_range(0, 65535) - 32768;
               oz = $urandom_range(0, 65535) - 32768;
            end
         endcase
         set_grid(rows, cols, ox, oz);
         req_idle_on = (phase < PHASES - 2) && ($urandom_range(0, 3) != 0);
         rsp_idle_on <= (phase < PHASES - 2) && ($urandom_range(0, 3) != 0);
         target = beats_sent + BEATS_PER_PHASE;
         while (beats_sent < target) random_item();
      end

      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (mismatches == 0 && pending == 0) begin
         $display("heightmap_bilinear_sampler test passed");
      end else begin
         $display("heightmap_bilinear_sampler test failed");
      end
      $finish;
   end

endmodule
